/* design/uuidp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID text parser package
// Shared types, constants and the hex digit decoder for the UUID text parser.
// ----------------------------------------------------------------------------
package uuidp_pkg;

	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned POS_W      = 6;
	localparam int unsigned HALF_W     = 64;
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned IN_TDATA_W = 8;
	localparam int unsigned OUT_DATA_W = STATUS_W + 2 * HALF_W;
	localparam int unsigned OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

	localparam logic [POS_W-1:0]  TEXT_LEN     = POS_W'(36);
	localparam logic [POS_W-1:0]  DIGITS       = POS_W'(32);
	localparam logic [POS_W-1:0]  POS_SATURATE = POS_W'(37);
	localparam logic [CHAR_W-1:0] HYPHEN_CHAR  = 8'h2D;
	localparam logic [3:0]        VERSION_4    = 4'h4;

	// Parse modes held in the configuration register.
	localparam logic MODE_STRICT = 1'b0;
	localparam logic MODE_LOOSE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_BAD_LENGTH = 3'd1,
		ST_BAD_HYPHEN = 3'd2,
		ST_BAD_HEX    = 3'd3,
		ST_BAD_VER    = 3'd4
	} status_t;

	typedef struct packed {
		logic               valid;
		logic [3:0]         nibble;
	} hex_t;

	typedef struct packed {
		status_t            status;
		logic [HALF_W-1:0]  uuid_high;
		logic [HALF_W-1:0]  uuid_low;
	} result_t;

	// Decodes one ASCII byte as a hex digit: 0-9, a-f and A-F.
	function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
		hex_t h;
		h.valid  = 1'b1;
		h.nibble = 4'h0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.nibble = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			h.nibble = 4'(c[2:0] + 3'd1) + 4'd8;
		end else begin
			h.valid = 1'b0;
		end
		return h;
	endfunction

endpackage

/* design/uuidp_parse_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID text parser core
// Holds the per-string state, updates it once per character and forms the
// result for the final character of a string.
// ----------------------------------------------------------------------------
module uuidp_parse_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [uuidp_pkg::CHAR_W-1:0] text_char,
	input  logic                         last_char,
	input  logic                         mode,
	output uuidp_pkg::result_t           result
);
	import uuidp_pkg::*;

	logic [POS_W-1:0]  char_position_q, pos_nxt;
	logic [POS_W-1:0]  digit_count_q, cnt_nxt;
	logic [HALF_W-1:0] high_q, high_nxt;
	logic [HALF_W-1:0] low_q, low_nxt;
	logic              flag_hyphen_q, hyphen_nxt;
	logic              flag_hex_q, hex_nxt;
	hex_t              hv;
	logic              do_shift;
	logic              hyphen_pos;
	status_t           status;

	assign hv = hex_decode(text_char);
	assign hyphen_pos = (char_position_q == POS_W'(8)) || (char_position_q == POS_W'(13)) ||
		(char_position_q == POS_W'(18)) || (char_position_q == POS_W'(23));

	// Next state for the character in hand.
	always_comb begin
		hyphen_nxt = flag_hyphen_q;
		hex_nxt    = flag_hex_q;
		do_shift   = 1'b0;
		if (mode == MODE_STRICT) begin
			if (char_position_q < TEXT_LEN) begin
				if (hyphen_pos) begin
					if (text_char != HYPHEN_CHAR) begin
						hyphen_nxt = 1'b1;
					end
				end else if (!hv.valid) begin
					hex_nxt = 1'b1;
				end else begin
					do_shift = 1'b1;
				end
			end
		end else begin
			if (digit_count_q < DIGITS && text_char != HYPHEN_CHAR) begin
				if (!hv.valid) begin
					hex_nxt = 1'b1;
				end else if (!flag_hex_q) begin
					do_shift = 1'b1;
				end
			end
		end
		// No digit is taken once the value is full.
		if (do_shift && digit_count_q < DIGITS) begin
			high_nxt = {high_q[HALF_W-5:0], low_q[HALF_W-1:HALF_W-4]};
			low_nxt  = {low_q[HALF_W-5:0], hv.nibble};
			cnt_nxt  = digit_count_q + POS_W'(1);
		end else begin
			high_nxt = high_q;
			low_nxt  = low_q;
			cnt_nxt  = digit_count_q;
		end
		pos_nxt = (char_position_q < POS_SATURATE) ? char_position_q + POS_W'(1)
			: char_position_q;
	end

	// Final status in order of precedence for the mode in force.
	always_comb begin
		if (mode == MODE_STRICT) begin
			if (pos_nxt != TEXT_LEN) begin
				status = ST_BAD_LENGTH;
			end else if (hyphen_nxt) begin
				status = ST_BAD_HYPHEN;
			end else if (hex_nxt) begin
				status = ST_BAD_HEX;
			end else if (cnt_nxt != DIGITS) begin
				status = ST_BAD_LENGTH;
			end else begin
				status = ST_OK;
			end
		end else begin
			if (hex_nxt) begin
				status = ST_BAD_HEX;
			end else if (cnt_nxt != DIGITS) begin
				status = ST_BAD_LENGTH;
			end else begin
				status = ST_OK;
			end
		end
		if (status == ST_OK && high_nxt[15:12] != VERSION_4) begin
			status = ST_BAD_VER;
		end
		result.status    = status;
		result.uuid_high = (status == ST_OK) ? high_nxt : '0;
		result.uuid_low  = (status == ST_OK) ? low_nxt : '0;
	end

	// State registers; a final character clears them for the next string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_position_q <= '0;
			digit_count_q   <= '0;
			high_q          <= '0;
			low_q           <= '0;
			flag_hyphen_q   <= 1'b0;
			flag_hex_q      <= 1'b0;
		end else if (step) begin
			if (last_char) begin
				char_position_q <= '0;
				digit_count_q   <= '0;
				high_q          <= '0;
				low_q           <= '0;
				flag_hyphen_q   <= 1'b0;
				flag_hex_q      <= 1'b0;
			end else begin
				char_position_q <= pos_nxt;
				digit_count_q   <= cnt_nxt;
				high_q          <= high_nxt;
				low_q           <= low_nxt;
				flag_hyphen_q   <= hyphen_nxt;
				flag_hex_q      <= hex_nxt;
			end
		end
	end

endmodule

/* design/uuid_v4_text_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID version 4 text parser, top level
// Turns a UUID string, one character per transfer, into a status and the
// 128-bit value.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one ASCII character per transfer, with s_tlast on
//   the final character of a string. Only that final character yields a
//   transfer on the master channel: the status and both halves of the value,
//   which are zero on any error.
//   cfg_we writes the parse mode (0 strict 36-character form, 1 loose hex);
//   the user must write it only while no string is in flight; the block
//   itself does not enforce this. Throughput is one character per cycle,
//   except that a final character waits while a result is stalled. The
//   result of a final character passes the input register, then the
//   result register.
//   When the receiver stalls, the result is held; non-final characters keep
//   flowing, and a second final character waits in the input register until
//   the result register frees.
//   Reset clears the parse mode to strict, all string state and the valid
//   flags of both channel registers.
// ----------------------------------------------------------------------------
module uuid_v4_text_parser_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata: text_char [7:0]
	input  logic [uuidp_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata: status [2:0], uuid_high [66:3], uuid_low [130:67], zero [135:131]
	output logic [uuidp_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import uuidp_pkg::*;

	logic                  parse_mode_q;
	logic                  valid_s1;
	logic [CHAR_W-1:0]     char_s1;
	logic                  last_s1;
	logic                  mode_s1;
	logic                  out_free;
	logic                  step;
	result_t               result;
	result_t               result_q;
	logic                  out_valid_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_mode_q <= MODE_STRICT;
		end else if (cfg_we) begin
			parse_mode_q <= cfg_wdata;
		end
	end

	// Handshake control: a non-final character always moves on.
	assign out_free = !out_valid_q || m_tready;
	assign step     = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata[CHAR_W-1:0];
			last_s1 <= s_tlast;
			mode_s1 <= parse_mode_q;
		end
	end

	uuidp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.text_char (char_s1),
		.last_char (last_s1),
		.mode      (mode_s1),
		.result    (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_DATA_W){1'b0}}, result_q.uuid_low,
		result_q.uuid_high, result_q.status};

endmodule

/* design/uuidp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID text parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module uuidp_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [uuidp_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import uuidp_pkg::*;

	// A stalled result transfer holds its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Status codes stay within the defined set.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= ST_BAD_VER)
		else $error("undefined status code");

	// An error result carries a zero value.
	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[130:3] == '0)
		else $error("error result with nonzero value");

	// A good result is always version 4.
	a_version: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == ST_OK |-> m_tdata[18:15] == VERSION_4)
		else $error("good result without version 4");

endmodule

bind uuid_v4_text_parser_top uuidp_checker u_uuidp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* tb/uuid_v4_text_parser_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID version 4 text parser testbench
// Streams UUID strings one character per transfer into the parser, in both
// parse modes, and checks every result against its typed value or against
// a cycle-free software parser kept inside this bench. A short table of
// hand-picked strings comes first; well-formed, mutated and noise strings
// with random content follow. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module uuid_v4_text_parser_top_tb;

	import uuidp_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 11;
	localparam int DRAIN_CYCLES = 4;
	localparam int TAIL_CYCLES  = 10;
	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_CHARS = 800;

	typedef logic [CHAR_W-1:0] text_q_t [$];

	// One row of the hand-picked strings; patch_at >= 0 overwrites one
	// character with a byte that a string literal cannot carry.
	typedef struct {
		logic              mode;
		string             text;
		int                patch_at;
		logic [CHAR_W-1:0] patch_char;
		bit                fixed;
		status_t           status;
		logic [HALF_W-1:0] uuid_high;
		logic [HALF_W-1:0] uuid_low;
	} text_case_t;

	// Per string: whether the result is typed in, and if so its value.
	typedef struct {
		bit      fixed;
		result_t value;
	} fixed_result_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic                   cfg_wdata = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   s_tlast   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b1;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// Parser state as the bench sees it.
	logic              mode_now    = MODE_STRICT;
	logic [POS_W-1:0]  seen_chars  = '0;
	logic [POS_W-1:0]  held_digits = '0;
	logic [HALF_W-1:0] value_hi    = '0;
	logic [HALF_W-1:0] value_lo    = '0;
	bit                bad_hyphen  = 1'b0;
	bit                bad_hex     = 1'b0;

	result_t       expected_results [$];
	fixed_result_t fixed_results [$];

	int errors          = 0;
	int results_checked = 0;
	int strings_sent    = 0;
	int chars_sent      = 0;
	int mode_writes     = 0;
	int quiet_cycles    = 0;
	int src_calm        = 0;
	int sink_calm       = 0;
	int stall_left      = 0;

	text_case_t directed_cases [24] = '{
		'{MODE_STRICT, "123e4567-e89b-42d3-a456-426614174000", -1, 8'h00,
			1'b1, ST_OK, 64'h123e4567e89b42d3, 64'ha456426614174000},
		'{MODE_STRICT, "00000000-0000-4000-0000-000000000000", -1, 8'h00,
			1'b1, ST_OK, 64'h0000000000004000, 64'h0000000000000000},
		'{MODE_STRICT, "ffffffff-ffff-4fff-ffff-ffffffffffff", -1, 8'h00,
			1'b1, ST_OK, 64'hffffffffffff4fff, 64'hffffffffffffffff},
		'{MODE_STRICT, "FEDCBA98-7654-4210-ABCD-EF0123456789", -1, 8'h00,
			1'b0, ST_OK, '0, '0},
		'{MODE_STRICT, "123e4567-e89b-12d3-a456-426614174000", -1, 8'h00,
			1'b1, ST_BAD_VER, '0, '0},
		'{MODE_STRICT, "123e4567-e89b-42d3-a456-42661417400", -1, 8'h00,
			1'b1, ST_BAD_LENGTH, '0, '0},
		'{MODE_STRICT, "123e4567-e89b-42d3-a456-4266141740001", -1, 8'h00,
			1'b1, ST_BAD_LENGTH, '0, '0},
		'{MODE_STRICT, "123e4567xe89b-42d3-a456-426614174000", -1, 8'h00,
			1'b1, ST_BAD_HYPHEN, '0, '0},
		'{MODE_STRICT, "123e-567-e89b-42d3-a456-426614174000", -1, 8'h00,
			1'b1, ST_BAD_HEX, '0, '0},
		'{MODE_STRICT, "123g4567-e89b+42d3-a456-426614174000", -1, 8'h00,
			1'b1, ST_BAD_HYPHEN, '0, '0},
		'{MODE_STRICT, "123e4567-e89b-42d3-a456-426614174000", 0, 8'h00,
			1'b1, ST_BAD_HEX, '0, '0},
		'{MODE_STRICT, "123e4567-e89b-42d3-a456-426614174000", 35, 8'hFF,
			1'b1, ST_BAD_HEX, '0, '0},
		'{MODE_STRICT, "7", -1, 8'h00,
			1'b1, ST_BAD_LENGTH, '0, '0},
		'{MODE_STRICT, "12zz", -1, 8'h00,
			1'b1, ST_BAD_LENGTH, '0, '0},
		'{MODE_STRICT, "123e4567e89b42d3a456426614174000", -1, 8'h00,
			1'b1, ST_BAD_LENGTH, '0, '0},
		'{MODE_LOOSE, "123e4567e89b42d3a456426614174000", -1, 8'h00,
			1'b1, ST_OK, 64'h123e4567e89b42d3, 64'ha456426614174000},
		'{MODE_LOOSE, "-123e-4567e89b42d3--a456426614174000-", -1, 8'h00,
			1'b1, ST_OK, 64'h123e4567e89b42d3, 64'ha456426614174000},
		'{MODE_LOOSE, "123e4567e89b42d3a456426614174000zz-9", 34, 8'hFF,
			1'b1, ST_OK, 64'h123e4567e89b42d3, 64'ha456426614174000},
		'{MODE_LOOSE, "123e4567-e89b-42d3-a456-426614174000", -1, 8'h00,
			1'b1, ST_OK, 64'h123e4567e89b42d3, 64'ha456426614174000},
		'{MODE_LOOSE, "123e4567e89b42d3a45642661417400", -1, 8'h00,
			1'b1, ST_BAD_LENGTH, '0, '0},
		'{MODE_LOOSE, "123e4567e89b42d3a456426614174000", 5, 8'h00,
			1'b1, ST_BAD_HEX, '0, '0},
		'{MODE_LOOSE, "123e4567e89b12d3a456426614174000", -1, 8'h00,
			1'b1, ST_BAD_VER, '0, '0},
		'{MODE_LOOSE, "12g4", -1, 8'h00,
			1'b1, ST_BAD_HEX, '0, '0},
		'{MODE_LOOSE, "ABCDEF0123454abcdef0123456789ABC", -1, 8'h00,
			1'b0, ST_OK, '0, '0}
	};

	uuid_v4_text_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #CLK_HALF clk = ~clk;

	// Draws an idle count of 0 to 15, with occasional runs of no idling.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm = $urandom_range(10, 60);
		end
		return $urandom_range(0, 15);
	endfunction

	function automatic logic [CHAR_W-1:0] hex_char(input int unsigned nib, input bit upper);
		if (nib < 10) begin
			return CHAR_W'(8'h30 + nib);
		end
		return CHAR_W'((upper ? 8'h41 : 8'h61) + nib - 10);
	endfunction

	function automatic bit decode_hex(input logic [CHAR_W-1:0] c, output logic [3:0] nib);
		nib = 4'h0;
		if (c >= 8'h30 && c <= 8'h39) begin
			nib = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			nib = 4'(c - 8'h61 + 8'd10);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			nib = 4'(c - 8'h41 + 8'd10);
		end else begin
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// Shifts one nibble into the 128-bit value unless 32 are already held.
	task automatic shift_digit(input logic [3:0] nib);
		if (held_digits < DIGITS) begin
			value_hi    = {value_hi[HALF_W-5:0], value_lo[HALF_W-1:HALF_W-4]};
			value_lo    = {value_lo[HALF_W-5:0], nib};
			held_digits = held_digits + 1'b1;
		end
	endtask

	// Applies one accepted character; on the final one, yields the result.
	task automatic parse_char(input logic [CHAR_W-1:0] c, input logic last,
			output bit produced, output result_t r);
		logic [3:0]       nib;
		bit               is_hex;
		logic [POS_W-1:0] p;
		status_t          st;
		is_hex   = decode_hex(c, nib);
		p        = seen_chars;
		produced = 1'b0;
		r        = '0;
		if (mode_now == MODE_STRICT) begin
			// Only the first 36 characters are looked at; the four separator
			// positions must hold hyphens.
			if (p < TEXT_LEN) begin
				if (p == 8 || p == 13 || p == 18 || p == 23) begin
					if (c != HYPHEN_CHAR) bad_hyphen = 1'b1;
				end else if (!is_hex) begin
					bad_hex = 1'b1;
				end else begin
					shift_digit(nib);
				end
			end
		end else if (held_digits < DIGITS && c != HYPHEN_CHAR) begin
			// Loose form: hyphens and anything past the 32nd digit are skipped.
			if (!is_hex) begin
				bad_hex = 1'b1;
			end else if (!bad_hex) begin
				shift_digit(nib);
			end
		end
		if (p < POS_SATURATE) seen_chars = p + 1'b1;

		if (last) begin
			if (mode_now == MODE_STRICT) begin
				if (seen_chars != TEXT_LEN) st = ST_BAD_LENGTH;
				else if (bad_hyphen) st = ST_BAD_HYPHEN;
				else if (bad_hex) st = ST_BAD_HEX;
				else if (held_digits != DIGITS) st = ST_BAD_LENGTH;
				else st = ST_OK;
			end else begin
				if (bad_hex) st = ST_BAD_HEX;
				else if (held_digits != DIGITS) st = ST_BAD_LENGTH;
				else st = ST_OK;
			end
			// The version nibble is the upper nibble of byte 6.
			if (st == ST_OK && value_hi[15:12] != VERSION_4) st = ST_BAD_VER;
			r.status = st;
			if (st == ST_OK) begin
				r.uuid_high = value_hi;
				r.uuid_low  = value_lo;
			end
			produced    = 1'b1;
			seen_chars  = '0;
			held_digits = '0;
			value_hi    = '0;
			value_lo    = '0;
			bad_hyphen  = 1'b0;
			bad_hex     = 1'b0;
		end
	endtask

	// Sends one string, one character per transfer, with tlast on the final one.
	task automatic send_text(input text_q_t txt, input bit fixed, input result_t value);
		int gap;
		fixed_results.push_back('{fixed, value});
		foreach (txt[i]) begin
			gap = draw_wait(src_calm);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= txt[i];
			s_tlast  <= (i == txt.size() - 1);
			do @(posedge clk); while (!s_tready);
		end
		strings_sent++;
		chars_sent += txt.size();
	endtask

	// Writes the parse mode once every result is back and the pipe has drained.
	task automatic set_mode(input logic m);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we   <= 1'b0;
		mode_now = m;
		mode_writes++;
	endtask

	// Receiver pacing: after each result transfer, hold tready low for a drawn idle count, which may be zero.
	always @(posedge clk) begin : sink_pacing
		int w;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= (stall_left == 1);
		end else if (m_tvalid && m_tready) begin
			w = draw_wait(sink_calm);
			stall_left <= w;
			m_tready   <= (w == 0);
		end
	end

	// Predicts on every character transfer and checks every result transfer.
	always @(posedge clk) begin : result_check
		bit                produced;
		result_t           predicted;
		result_t           want;
		fixed_result_t     row;
		status_t           got_status;
		logic [HALF_W-1:0] got_high;
		logic [HALF_W-1:0] got_low;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				parse_char(s_tdata, s_tlast, produced, predicted);
				if (produced) begin
					row = fixed_results.pop_front();
					expected_results.push_back(row.fixed ? row.value : predicted);
				end
			end
			if (m_tvalid && m_tready) begin
				got_status = status_t'(m_tdata[STATUS_W-1:0]);
				got_high   = m_tdata[STATUS_W +: HALF_W];
				got_low    = m_tdata[STATUS_W + HALF_W +: HALF_W];
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: status %0d, value %h_%h",
						$time, got_status, got_high, got_low);
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (got_status != want.status) begin
						errors++;
						$display("%0t: status mismatch: expected %0d, got %0d",
							$time, want.status, got_status);
					end
					if (got_high != want.uuid_high) begin
						errors++;
						$display("%0t: uuid_high mismatch: expected %h, got %h",
							$time, want.uuid_high, got_high);
					end
					if (got_low != want.uuid_low) begin
						errors++;
						$display("%0t: uuid_low mismatch: expected %h, got %h",
							$time, want.uuid_low, got_low);
					end
				end
			end
		end
	end

	// Counts cycles without any transfer on either channel.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		text_q_t    txt;
		text_case_t tc;
		int         kind;
		int         pos;
		int         len;
		int         random_start;
		int         strings_left;
		bit         loose_form;
		bit         keep_version;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hand-picked strings.
		foreach (directed_cases[k]) begin
			tc = directed_cases[k];
			if (tc.mode != mode_now) set_mode(tc.mode);
			txt.delete();
			for (int i = 0; i < tc.text.len(); i++) txt.push_back(tc.text[i]);
			if (tc.patch_at >= 0) txt[tc.patch_at] = tc.patch_char;
			send_text(txt, tc.fixed, '{tc.status, tc.uuid_high, tc.uuid_low});
		end

		// Random phases, each under one parse mode.
		random_start = chars_sent;
		while (chars_sent - random_start < RANDOM_CHARS) begin
			set_mode(1'($urandom_range(0, 1)));
			strings_left = $urandom_range(4, 10);
			while (strings_left > 0) begin
				strings_left--;
				txt.delete();
				kind         = $urandom_range(0, 9);
				loose_form   = (kind < 7) ? (mode_now == MODE_LOOSE) : (mode_now != MODE_LOOSE);
				keep_version = ($urandom_range(0, 9) != 0);
				if (kind == 9) begin
					// Noise, long enough at times to saturate the position count.
					len = $urandom_range(1, 45);
					repeat (len) begin
						if ($urandom_range(0, 3) == 0) begin
							txt.push_back(hex_char($urandom_range(0, 15),
								1'($urandom_range(0, 1))));
						end else begin
							txt.push_back(CHAR_W'($urandom_range(0, 255)));
						end
					end
				end else if (loose_form) begin
					for (int d = 0; d < 32; d++) begin
						if ($urandom_range(0, 5) == 0) txt.push_back(HYPHEN_CHAR);
						txt.push_back(hex_char((d == 12 && keep_version) ? 4 :
							$urandom_range(0, 15), 1'($urandom_range(0, 1))));
					end
					repeat ($urandom_range(0, 4)) txt.push_back(CHAR_W'($urandom_range(0, 255)));
				end else begin
					for (int i = 0; i < 36; i++) begin
						if (i == 8 || i == 13 || i == 18 || i == 23) begin
							txt.push_back(HYPHEN_CHAR);
						end else begin
							txt.push_back(hex_char((i == 14 && keep_version) ? 4 :
								$urandom_range(0, 15), 1'($urandom_range(0, 1))));
						end
					end
				end

				// Break some well-formed strings in one place.
				if (kind != 9 && $urandom_range(0, 3) == 0) begin
					pos = $urandom_range(0, txt.size() - 1);
					case ($urandom_range(0, 3))
						0: begin
							txt[pos] = CHAR_W'($urandom_range(0, 255));
						end
						1: begin
							txt.delete(pos);
						end
						2: begin
							txt.insert(pos, CHAR_W'($urandom_range(0, 255)));
						end
						default: begin
							while (txt.size() > pos + 1) void'(txt.pop_back());
						end
					endcase
				end
				send_text(txt, 1'b0, '0);
			end
		end

		// Let every result come back, then a few more cycles for stray output.
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d strings (%0d characters) across %0d parse-mode writes.",
			strings_sent, chars_sent, mode_writes);
		$display("Checked %0d results with %0d mismatches.", results_checked, errors);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* files.f */
design/uuidp_pkg.sv
design/uuidp_parse_core.sv
design/uuid_v4_text_parser_top.sv
design/uuidp_checker.sv
tb/uuid_v4_text_parser_top_tb.sv
